// ----- src/cbt_pkg.sv -----
`default_nettype none

package cbt_pkg;

    // Field widths
    localparam int BUDGET_W = 31;
    localparam int ROB_W    = 32;
    localparam int RATE_W   = 17;
    localparam int CMD_W    = 2;
    localparam int FILL_W   = 9;
    localparam int CFG_IDX_W = 2;

    // Intermediate widths
    localparam int BSUM_W = 34;             // budget + robustness, signed
    localparam int PROD_W = BUDGET_W + RATE_W; // baseline * rate
    localparam int ADP_W  = BSUM_W + 16 + 2;  // (budget + rob) * 2^16 - prod, signed
    localparam int CAND_W = ADP_W - 16;

    // Commands
    localparam logic [CMD_W-1:0] CMD_PLAIN    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADAPTIVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE     = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOAD_BUDGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CEILING     = 2'd2;

    localparam logic [BUDGET_W-1:0] CEILING_RST = 31'd6553600;

    typedef logic [BUDGET_W-1:0] budget_t;

endpackage

`default_nettype wire

// ----- src/cbt_ram.sv -----
`default_nettype none

// Simple dual-port RAM, one write and one registered read port.
module cbt_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 256,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AddrW-1:0] wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AddrW-1:0] rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- src/cbt_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module cbt_div #(
    parameter int DIVIDEND_W = 40,
    parameter int DIVISOR_W  = 9
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       busy,
    output logic [DIVIDEND_W-1:0]      quotient
);

    localparam int CountW = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  den_reg;
    logic [CountW-1:0]     cnt_reg;
    logic                  busy_reg;

    logic [DIVISOR_W:0] shifted;
    logic [DIVISOR_W:0] diff;
    logic               fits;

    always_comb begin
        shifted  = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff     = shifted - {1'b0, den_reg};
        fits     = shifted >= {1'b0, den_reg};
        rem_next = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CountW'(DIVIDEND_W);
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != CountW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- src/clamped_budget_tracker_with_window_stats.sv -----
`default_nettype none

// Clamped budget tracker with window statistics. Each item carries a command:
// plain update (budget += robustness - baseline), adaptive update (budget +=
// robustness - baseline * rate / 2^16, floored), clear (budget and window to
// zero), or no-op. Updated budgets are clamped to [0, ceiling] and pushed
// into a HISTORY_DEPTH-entry window held in one RAM. Every item returns one
// result: budget, window min, max, truncated mean and fill count; with an
// empty window all statistics equal the budget. Values are unsigned Q15.16.
// One item is in flight at a time. An update passes ST_MUL, ST_UPD, ST_PUSH,
// ST_SCAN and ST_DONE; a clear or no-op skips ST_PUSH. In ST_SCAN min/max
// walk the RAM's read port one entry a cycle over the entries held after
// the item, while the bit-serial mean divider runs alongside the walk.
// A finished result waits while the previous one is still held on
// m_ready. A new item is taken while the last result still waits on m_ready.
// Config writes (cfg_wr_en) must come only while idle; writing register 0
// (starting budget) loads the live budget. No clearing pass after reset.
module clamped_budget_tracker_with_window_stats #(
    parameter int HISTORY_DEPTH = 256
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // config
    input  wire logic                            cfg_wr_en,
    input  wire logic [cbt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [cbt_pkg::BUDGET_W-1:0]    cfg_wr_data,
    // input items
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [cbt_pkg::CMD_W-1:0]       s_command,
    input  wire logic signed [cbt_pkg::ROB_W-1:0] s_robustness,
    input  wire logic [cbt_pkg::RATE_W-1:0]      s_satisfaction_rate,
    // result items
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [cbt_pkg::BUDGET_W-1:0]         m_budget_now,
    output logic [cbt_pkg::BUDGET_W-1:0]         m_window_min,
    output logic [cbt_pkg::BUDGET_W-1:0]         m_window_max,
    output logic [cbt_pkg::BUDGET_W-1:0]         m_window_mean,
    output logic [cbt_pkg::FILL_W-1:0]           m_fill_count
);

    localparam int PtrW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CntW = $clog2(HISTORY_DEPTH + 1);
    localparam int SumW = cbt_pkg::BUDGET_W + CntW;

    localparam logic [CntW-1:0] DEPTH_CNT = CntW'(HISTORY_DEPTH);
    localparam logic [PtrW-1:0] LAST_PTR  = PtrW'(HISTORY_DEPTH - 1);

    // FSM codes
    localparam logic [2:0] ST_IDLE = 3'd0;  // wait for an item
    localparam logic [2:0] ST_MUL  = 3'd1;  // baseline*rate, budget+rob, read oldest
    localparam logic [2:0] ST_UPD  = 3'd2;  // new budget, clamp; or clear
    localparam logic [2:0] ST_PUSH = 3'd3;  // write window, update sum/count
    localparam logic [2:0] ST_SCAN = 3'd4;  // min/max walk + mean divide
    localparam logic [2:0] ST_DONE = 3'd5;  // hand result to output register

    logic [2:0] state_reg, state_next;

    // configuration
    cbt_pkg::budget_t baseline_reg;
    cbt_pkg::budget_t ceiling_reg;

    // architectural state
    cbt_pkg::budget_t budget_reg;
    logic [PtrW-1:0]  wp_reg;
    logic [CntW-1:0]  held_reg;
    logic [SumW-1:0]  sum_reg;

    // item latch and datapath regs
    logic [cbt_pkg::CMD_W-1:0]        cmd_reg;
    logic signed [cbt_pkg::ROB_W-1:0] rob_reg;
    logic [cbt_pkg::RATE_W-1:0]       rate_reg;
    logic [cbt_pkg::PROD_W-1:0]       prod_reg;
    logic signed [cbt_pkg::BSUM_W-1:0] bsum_reg;

    // scan
    logic [CntW-1:0]  issue_reg;
    logic             rd_valid_reg;
    cbt_pkg::budget_t min_reg;
    cbt_pkg::budget_t max_reg;
    logic             div_started_reg;

    // outputs
    logic             m_valid_reg;
    cbt_pkg::budget_t out_budget_reg;
    cbt_pkg::budget_t out_min_reg;
    cbt_pkg::budget_t out_max_reg;
    cbt_pkg::budget_t out_mean_reg;
    logic [cbt_pkg::FILL_W-1:0] out_fill_reg;

    // RAM
    logic             ram_rd_en;
    logic [PtrW-1:0]  ram_rd_addr;
    cbt_pkg::budget_t ram_rd_data;
    logic             ram_wr_en;

    // divider
    logic             div_start;
    logic             div_busy;
    logic [SumW-1:0]  div_quotient;

    logic s_fire;
    logic out_load;
    logic scan_done;
    logic is_update;
    logic window_full;

    assign s_ready     = (state_reg == ST_IDLE);
    assign s_fire      = s_valid && s_ready;
    assign is_update   = (cmd_reg == cbt_pkg::CMD_PLAIN) || (cmd_reg == cbt_pkg::CMD_ADAPTIVE);
    assign window_full = (held_reg == DEPTH_CNT);

    // ---------------------------------------------------------------
    // Budget update: exact signed arithmetic, then clamp
    // ---------------------------------------------------------------
    logic signed [cbt_pkg::BSUM_W-1:0] plain_v;
    logic signed [cbt_pkg::ADP_W-1:0]  adp_v;
    logic [cbt_pkg::CAND_W-1:0]        cand;
    logic                              nonpos;
    cbt_pkg::budget_t                  new_budget;

    always_comb begin
        plain_v = bsum_reg - $signed({3'b000, baseline_reg});
        adp_v   = $signed({{2{bsum_reg[cbt_pkg::BSUM_W-1]}}, bsum_reg, 16'h0000})
                - $signed({4'h0, prod_reg});
        if (cmd_reg == cbt_pkg::CMD_ADAPTIVE) begin
            nonpos = adp_v[cbt_pkg::ADP_W-1] || (adp_v == '0);
            cand   = adp_v[cbt_pkg::ADP_W-1:16];
        end else begin
            nonpos = plain_v[cbt_pkg::BSUM_W-1] || (plain_v == '0);
            cand   = cbt_pkg::CAND_W'(plain_v);
        end
        if (nonpos) begin
            new_budget = '0;
        end else if (cand > cbt_pkg::CAND_W'(ceiling_reg)) begin
            new_budget = ceiling_reg;
        end else begin
            new_budget = cand[cbt_pkg::BUDGET_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Control
    // ---------------------------------------------------------------
    assign scan_done = (issue_reg == held_reg) && !rd_valid_reg
                     && div_started_reg && !div_busy;
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
    assign div_start = (state_reg == ST_SCAN) && !div_started_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_fire) state_next = ST_MUL;
            ST_MUL:  state_next = ST_UPD;
            ST_UPD:  state_next = is_update ? ST_PUSH : ST_SCAN;
            ST_PUSH: state_next = ST_SCAN;
            ST_SCAN: if (scan_done) state_next = ST_DONE;
            ST_DONE: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // config registers and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baseline_reg <= '0;
            ceiling_reg  <= cbt_pkg::CEILING_RST;
            budget_reg   <= '0;
            wp_reg       <= '0;
            held_reg     <= '0;
            sum_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    cbt_pkg::REG_LOAD_BUDGET: budget_reg   <= cfg_wr_data;
                    cbt_pkg::REG_BASELINE:    baseline_reg <= cfg_wr_data;
                    cbt_pkg::REG_CEILING:     ceiling_reg  <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_UPD) begin
                if (is_update) begin
                    budget_reg <= new_budget;
                end else if (cmd_reg == cbt_pkg::CMD_CLEAR) begin
                    budget_reg <= '0;
                    wp_reg     <= '0;
                    held_reg   <= '0;
                    sum_reg    <= '0;
                end
            end
            if (state_reg == ST_PUSH) begin
                // ram_rd_data still holds the entry at wp read in ST_MUL
                sum_reg <= sum_reg - (window_full ? SumW'(ram_rd_data) : '0)
                         + SumW'(budget_reg);
                if (!window_full) begin
                    held_reg <= held_reg + 1'b1;
                end
                wp_reg <= (wp_reg == LAST_PTR) ? '0 : wp_reg + 1'b1;
            end
        end
    end

    // item latch and first arithmetic stage
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg  <= s_command;
            rob_reg  <= s_robustness;
            rate_reg <= s_satisfaction_rate;
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= baseline_reg * rate_reg;
            bsum_reg <= $signed({3'b000, budget_reg})
                      + cbt_pkg::BSUM_W'(rob_reg);
        end
    end

    // ---------------------------------------------------------------
    // Window RAM
    // ---------------------------------------------------------------
    always_comb begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = wp_reg;
        if (state_reg == ST_MUL) begin
            ram_rd_en = 1'b1;
        end else if ((state_reg == ST_SCAN) && (issue_reg != held_reg)) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = issue_reg[PtrW-1:0];
        end
    end

    assign ram_wr_en = (state_reg == ST_PUSH);

    cbt_ram #(
        .WIDTH (cbt_pkg::BUDGET_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (wp_reg),
        .wr_data (budget_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // ---------------------------------------------------------------
    // Min/max walk over entries 0..held-1
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg       <= '0;
            rd_valid_reg    <= 1'b0;
            div_started_reg <= 1'b0;
        end else if (state_reg == ST_SCAN) begin
            rd_valid_reg <= ram_rd_en;
            if (ram_rd_en) begin
                issue_reg <= issue_reg + 1'b1;
            end
            div_started_reg <= 1'b1;
        end else begin
            issue_reg       <= '0;
            rd_valid_reg    <= 1'b0;
            div_started_reg <= 1'b0;
        end
    end

    // seeded while idle so the result survives a stall in ST_DONE
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) begin
            min_reg <= '1;
            max_reg <= '0;
        end else if ((state_reg == ST_SCAN) && rd_valid_reg) begin
            if (ram_rd_data < min_reg) min_reg <= ram_rd_data;
            if (ram_rd_data > max_reg) max_reg <= ram_rd_data;
        end
    end

    // mean = sum / held
    cbt_div #(
        .DIVIDEND_W (SumW),
        .DIVISOR_W  (CntW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (held_reg),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_budget_reg <= budget_reg;
            out_fill_reg   <= cbt_pkg::FILL_W'(held_reg);
            if (held_reg == '0) begin
                // empty window: stats follow the budget
                out_min_reg  <= budget_reg;
                out_max_reg  <= budget_reg;
                out_mean_reg <= budget_reg;
            end else begin
                out_min_reg  <= min_reg;
                out_max_reg  <= max_reg;
                out_mean_reg <= div_quotient[cbt_pkg::BUDGET_W-1:0];
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_budget_now  = out_budget_reg;
    assign m_window_min  = out_min_reg;
    assign m_window_max  = out_max_reg;
    assign m_window_mean = out_mean_reg;
    assign m_fill_count  = out_fill_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= DEPTH_CNT)
        else $error("window count above depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (held_reg == '0) |-> (sum_reg == '0))
        else $error("empty window with nonzero sum");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !div_busy)
        else $error("divider busy while idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg)
        else $error("result loaded but not presented");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (issue_reg <= held_reg))
        else $error("walk ran past held entries");

endmodule

`default_nettype wire
